// ----- hdl/tgarle_pkg.sv -----
package tgarle_pkg;

   // Packet header fields
   localparam int unsigned RUN_FLAG_BIT = 7;
   localparam logic [6:0] LEN_MASK = 7'd127;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWAP_RED_BLUE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOTAL_PIXELS = 2'd2;
   localparam int unsigned CSR_DATA_W = 30;

   localparam int unsigned PIXEL_W = 32;
   localparam int unsigned TOTAL_W = 30;
   localparam int unsigned REPEAT_W = 8;

   // Job queue between front and back
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_AW = 2;

   // Front parser phase
   typedef enum logic [0:0] {
      PH_HEADER = 1'b0,
      PH_PIXEL  = 1'b1
   } phase_type;

   // One decoded pixel with its repeat count
   typedef struct packed {
      logic [PIXEL_W-1:0]  pixel;
      logic [REPEAT_W-1:0] repeats;
      logic                image_end;
   } job_type;

   // Queue status seen by the producer and consumer
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

// ----- hdl/tgarle_fifo.sv -----
module tgarle_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  tgarle_pkg::job_type      push_job,
   input  logic                     pop,
   output tgarle_pkg::job_type      head_job,
   output tgarle_pkg::fifo_stat_type stat
);

   tgarle_pkg::job_type                   mem_ff [tgarle_pkg::FIFO_DEPTH];
   logic [tgarle_pkg::FIFO_AW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [tgarle_pkg::FIFO_AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [tgarle_pkg::FIFO_AW:0]          fill_ff, fill_in;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job   = mem_ff[rd_ptr_ff];
   assign stat.full  = (fill_ff == (tgarle_pkg::FIFO_AW+1)'(tgarle_pkg::FIFO_DEPTH));
   assign stat.empty = (fill_ff == '0);

endmodule

// ----- hdl/tgarle_front.sv -----
module tgarle_front (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration writes
   input  logic                                  csr_valid,
   input  logic [tgarle_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tgarle_pkg::CSR_DATA_W-1:0]     csr_data,
   // byte stream
   input  logic                                  byte_valid,
   input  logic [7:0]                            data_byte,
   // job queue
   output logic                                  push,
   output tgarle_pkg::job_type                   push_job
);

   tgarle_pkg::phase_type                 phase_ff, phase_in;
   logic                                  is_run_ff, is_run_in;
   logic [6:0]                            remaining_ff, remaining_in;
   logic [1:0]                            byte_pos_ff, byte_pos_in;
   logic [tgarle_pkg::PIXEL_W-1:0]        assembly_ff, assembly_in;
   logic [tgarle_pkg::TOTAL_W-1:0]        done_ff, done_in;

   logic [2:0]                            bpp_reg_ff;
   logic                                  swap_ff;
   logic [tgarle_pkg::TOTAL_W-1:0]        total_ff;

   logic [2:0]                            bpp;
   logic [2:0]                            next_pos;
   logic                                  pixel_done;
   logic [tgarle_pkg::PIXEL_W-1:0]        asm_full;
   logic [tgarle_pkg::PIXEL_W-1:0]        mask;
   logic [tgarle_pkg::PIXEL_W-1:0]        px_masked;
   logic [tgarle_pkg::PIXEL_W-1:0]        px;
   logic [tgarle_pkg::TOTAL_W-1:0]        total_eff;
   logic [tgarle_pkg::TOTAL_W-1:0]        left;
   logic [tgarle_pkg::REPEAT_W-1:0]       count_raw;
   logic                                  ends;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_reg_ff <= 3'd4;
         swap_ff    <= 1'b0;
         total_ff   <= {{(tgarle_pkg::TOTAL_W-1){1'b0}}, 1'b1};
      end else if (csr_valid) begin
         unique case (csr_index)
            tgarle_pkg::CSR_BYTES_PER_PIXEL: bpp_reg_ff <= csr_data[2:0];
            tgarle_pkg::CSR_SWAP_RED_BLUE:   swap_ff    <= csr_data[0];
            tgarle_pkg::CSR_TOTAL_PIXELS:    total_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Pixel size clamped to 1..4
   always_comb begin
      if (bpp_reg_ff == 3'd0) begin
         bpp = 3'd1;
      end else if (bpp_reg_ff > 3'd4) begin
         bpp = 3'd4;
      end else begin
         bpp = bpp_reg_ff;
      end
   end

   assign next_pos   = {1'b0, byte_pos_ff} + 3'd1;
   assign pixel_done = (phase_ff == tgarle_pkg::PH_PIXEL) && (next_pos >= bpp);
   assign asm_full   = assembly_ff | ({24'd0, data_byte} << {byte_pos_ff, 3'b000});

   // Pixel finishing: trim to size, optional byte 0/2 swap
   always_comb begin
      case (bpp)
         3'd1:    mask = 32'h0000_00FF;
         3'd2:    mask = 32'h0000_FFFF;
         3'd3:    mask = 32'h00FF_FFFF;
         default: mask = 32'hFFFF_FFFF;
      endcase
      px_masked = asm_full & mask;
      if (swap_ff && bpp >= 3'd3) begin
         px = {px_masked[31:24], px_masked[7:0], px_masked[15:8], px_masked[23:16]};
      end else begin
         px = px_masked;
      end
   end

   // Repeat count, clipped at the image end
   always_comb begin
      total_eff = (total_ff == '0) ? {{(tgarle_pkg::TOTAL_W-1){1'b0}}, 1'b1} : total_ff;
      left      = (total_eff > done_ff) ? (total_eff - done_ff)
                                        : {{(tgarle_pkg::TOTAL_W-1){1'b0}}, 1'b1};
      count_raw = is_run_ff ? ({1'b0, remaining_ff} + 8'd1) : 8'd1;
      ends      = ({{(tgarle_pkg::TOTAL_W-tgarle_pkg::REPEAT_W){1'b0}}, count_raw} >= left);
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (byte_valid) begin
         unique case (phase_ff)
            tgarle_pkg::PH_HEADER: phase_in = tgarle_pkg::PH_PIXEL;
            tgarle_pkg::PH_PIXEL: begin
               if (pixel_done && (ends || is_run_ff || remaining_ff == '0)) begin
                  phase_in = tgarle_pkg::PH_HEADER;
               end
            end
            default: phase_in = tgarle_pkg::PH_HEADER;
         endcase
      end
   end

   // Datapath and queue push
   always_comb begin
      is_run_in    = is_run_ff;
      remaining_in = remaining_ff;
      byte_pos_in  = byte_pos_ff;
      assembly_in  = assembly_ff;
      done_in      = done_ff;
      push         = 1'b0;
      push_job.pixel     = px;
      push_job.repeats   = ends ? left[tgarle_pkg::REPEAT_W-1:0] : count_raw;
      push_job.image_end = ends;
      if (byte_valid) begin
         unique case (phase_ff)
            tgarle_pkg::PH_HEADER: begin
               is_run_in    = data_byte[tgarle_pkg::RUN_FLAG_BIT];
               remaining_in = data_byte[6:0] & tgarle_pkg::LEN_MASK;
               byte_pos_in  = '0;
               assembly_in  = '0;
            end
            tgarle_pkg::PH_PIXEL: begin
               if (!pixel_done) begin
                  byte_pos_in = next_pos[1:0];
                  assembly_in = asm_full;
               end else begin
                  push        = 1'b1;
                  byte_pos_in = '0;
                  assembly_in = '0;
                  if (ends) begin
                     done_in      = '0;
                     remaining_in = '0;
                  end else begin
                     done_in = done_ff + {{(tgarle_pkg::TOTAL_W-tgarle_pkg::REPEAT_W){1'b0}},
                                          count_raw};
                     if (is_run_ff || remaining_ff == '0) begin
                        remaining_in = '0;
                     end else begin
                        remaining_in = remaining_ff - 7'd1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= tgarle_pkg::PH_HEADER;
         is_run_ff    <= 1'b0;
         remaining_ff <= '0;
         byte_pos_ff  <= '0;
         assembly_ff  <= '0;
         done_ff      <= '0;
      end else begin
         phase_ff     <= phase_in;
         is_run_ff    <= is_run_in;
         remaining_ff <= remaining_in;
         byte_pos_ff  <= byte_pos_in;
         assembly_ff  <= assembly_in;
         done_ff      <= done_in;
      end
   end

endmodule

// ----- hdl/tgarle_back.sv -----
module tgarle_back (
   input  logic                             clock,
   input  logic                             reset,
   // job queue
   input  tgarle_pkg::job_type              head_job,
   input  tgarle_pkg::fifo_stat_type        stat,
   output logic                             pop,
   // result stream
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [tgarle_pkg::PIXEL_W-1:0]   first_pixel,
   output logic [tgarle_pkg::PIXEL_W-1:0]   second_pixel,
   output logic [1:0]                       pixel_count,
   output logic                             run_end,
   output logic                             image_end
);

   logic                              busy_ff, busy_in;
   logic [tgarle_pkg::PIXEL_W-1:0]    px_ff, px_in;
   logic [tgarle_pkg::REPEAT_W-1:0]   cnt_ff, cnt_in;
   logic                              ends_ff, ends_in;

   logic                              out_valid_ff, out_valid_in;
   logic [tgarle_pkg::PIXEL_W-1:0]    out_first_ff, out_first_in;
   logic [tgarle_pkg::PIXEL_W-1:0]    out_second_ff, out_second_in;
   logic [1:0]                        out_count_ff, out_count_in;
   logic                              out_last_ff, out_last_in;
   logic                              out_iend_ff, out_iend_in;

   logic                              advance;
   logic                              emit;
   logic                              pair;
   logic                              last;

   // One or two pixels per result transaction
   assign advance = !out_valid_ff || rsp_ready;
   assign emit    = busy_ff && advance;
   assign pair    = (cnt_ff >= 8'd2);
   assign last    = pair ? (cnt_ff == 8'd2) : 1'b1;
   assign pop     = !stat.empty && (!busy_ff || (emit && last));

   // Job expansion
   always_comb begin
      busy_in = busy_ff;
      px_in   = px_ff;
      cnt_in  = cnt_ff;
      ends_in = ends_ff;
      if (pop) begin
         busy_in = 1'b1;
         px_in   = head_job.pixel;
         cnt_in  = head_job.repeats;
         ends_in = head_job.image_end;
      end else if (emit) begin
         busy_in = !last;
         cnt_in  = cnt_ff - (pair ? 8'd2 : 8'd1);
      end
   end

   // Output register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_first_in  = out_first_ff;
      out_second_in = out_second_ff;
      out_count_in  = out_count_ff;
      out_last_in   = out_last_ff;
      out_iend_in   = out_iend_ff;
      if (emit) begin
         out_valid_in  = 1'b1;
         out_first_in  = px_ff;
         out_second_in = pair ? px_ff : '0;
         out_count_in  = pair ? 2'd2 : 2'd1;
         out_last_in   = last;
         out_iend_in   = last && ends_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff         <= px_in;
      cnt_ff        <= cnt_in;
      ends_ff       <= ends_in;
      out_first_ff  <= out_first_in;
      out_second_ff <= out_second_in;
      out_count_ff  <= out_count_in;
      out_last_ff   <= out_last_in;
      out_iend_ff   <= out_iend_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign first_pixel  = out_first_ff;
   assign second_pixel = out_second_ff;
   assign pixel_count  = out_count_ff;
   assign run_end      = out_last_ff;
   assign image_end    = out_iend_ff;

endmodule

// ----- hdl/tga_rle_pixel_decoder.sv -----
// Run-length targa pixel decoder. Feed the pixel-data bytes of an RLE image,
// one byte per req transaction; results carry one or two decoded pixels each
// (byte 0 of a pixel in its low bits unless swap_red_blue swaps it with byte 2),
// with tlast on the last result of an input byte and tuser on the result that
// holds the image's final pixel, after which the block waits for a new image.
// The front parser takes one byte every cycle; a completed pixel becomes a job
// in a 4-entry queue and the back end expands it at two pixels per cycle unless
// the result port stalls, so a run of N pixels takes ceil(N/2) results, and the
// input stalls only once the queue is full. Program bytes_per_pixel,
// swap_red_blue and total_pixels over the csr port while the block is idle.
module tga_rle_pixel_decoder (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tgarle_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tgarle_pkg::CSR_DATA_W-1:0]   csr_data,
   // encoded bytes
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [7:0] data_byte
   // decoded pixels
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [71:0]                         rsp_tdata,  // [31:0] first_pixel,
                                                           // [63:32] second_pixel,
                                                           // [65:64] pixel_count, rest 0
   output logic                                rsp_tlast,  // run_end
   output logic                                rsp_tuser   // [0] image_end
);

   tgarle_pkg::job_type          push_job;
   tgarle_pkg::job_type          head_job;
   tgarle_pkg::fifo_stat_type    stat;
   logic                         push;
   logic                         pop;
   logic                         byte_accept;
   logic [31:0]                  first_pixel;
   logic [31:0]                  second_pixel;
   logic [1:0]                   pixel_count;

   assign csr_ready   = 1'b1;
   assign req_tready  = !stat.full;
   assign byte_accept = req_tvalid && req_tready;

   tgarle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .byte_valid (byte_accept),
      .data_byte  (req_tdata),
      .push       (push),
      .push_job   (push_job)
   );

   tgarle_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .stat     (stat)
   );

   tgarle_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_job     (head_job),
      .stat         (stat),
      .pop          (pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .first_pixel  (first_pixel),
      .second_pixel (second_pixel),
      .pixel_count  (pixel_count),
      .run_end      (rsp_tlast),
      .image_end    (rsp_tuser)
   );

   assign rsp_tdata = {6'd0, pixel_count, second_pixel, first_pixel};

   // A job is only pushed when the queue has room
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !stat.full)
      else $error("job queue overflow");

   // Only the last result of a byte may carry a single pixel
   a_pair_unless_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (pixel_count == 2'd2))
      else $error("single pixel result before end of run");

   // Image end always closes the byte's results
   a_iend_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("image end without run end");

   // Both pixels of a pair are the same run pixel
   a_pair_equal: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && pixel_count == 2'd2) |-> (second_pixel == first_pixel))
      else $error("pixel pair mismatch");

endmodule

// ----- test/tga_rle_decode_check.sv -----
// Watches the csr, req and rsp channels of the targa RLE decoder, keeps its
// own copy of the decode state and compares every rsp transaction with the
// oldest pixel result still owed.
module tga_rle_decode_check
   import tgarle_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [71:0]            rsp_tdata,
   input  logic                   rsp_tlast,
   input  logic                   rsp_tuser,
   output int                     results_pending,
   output int                     failures
);

   typedef struct packed {
      logic [PIXEL_W-1:0] first_pixel;
      logic [PIXEL_W-1:0] second_pixel;
      logic [1:0]         pixel_count;
      logic               run_end;
      logic               image_end;
   } pixel_result_type;

   pixel_result_type expected_pixels[$];
   int error_count = 0;

   // programmed registers
   logic [2:0]         cfg_bpp;
   logic               cfg_swap;
   logic [TOTAL_W-1:0] cfg_total;

   // decode state
   phase_type          parse_phase;
   logic               in_run;
   logic [7:0]         pixels_left;
   logic [1:0]         byte_pos;
   logic [PIXEL_W-1:0] assembly;
   logic [TOTAL_W-1:0] image_count;

   // One encoded byte: header, partial pixel, or a completed pixel that
   // expands into results of up to two pixels each.
   task automatic decode_byte(input logic [7:0] b);
      int unsigned bpp, total, left, count;
      logic [PIXEL_W-1:0] px, mask;
      logic closes_image;
      pixel_result_type res;
      bpp = (cfg_bpp == 3'd0) ? 1 : ((cfg_bpp > 3'd4) ? 4 : cfg_bpp);
      if (parse_phase == PH_HEADER) begin
         in_run = b[RUN_FLAG_BIT];
         pixels_left = {1'b0, b[6:0] & LEN_MASK};
         parse_phase = PH_PIXEL;
         byte_pos = 2'd0;
         assembly = '0;
         return;
      end
      assembly |= 32'(b) << (8 * byte_pos);
      if (byte_pos + 1 < bpp) begin
         byte_pos = byte_pos + 2'd1;
         return;
      end
      mask = (bpp >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * bpp)) - 32'd1);
      px = assembly & mask;
      if (cfg_swap && bpp >= 3)
         px = {px[31:24], px[7:0], px[15:8], px[23:16]};
      byte_pos = 2'd0;
      assembly = '0;

      // clip the packet at the image total
      total = (cfg_total == '0) ? 1 : cfg_total;
      left = (total > image_count) ? total - image_count : 1;
      count = in_run ? pixels_left + 1 : 1;
      closes_image = 1'b0;
      if (count >= left) begin
         count = left;
         closes_image = 1'b1;
      end
      while (count > 0) begin
         res.pixel_count = (count >= 2) ? 2'd2 : 2'd1;
         res.first_pixel = px;
         res.second_pixel = (count >= 2) ? px : '0;
         res.run_end = (count == res.pixel_count);
         res.image_end = res.run_end & closes_image;
         expected_pixels.push_back(res);
         count -= res.pixel_count;
         image_count = image_count + TOTAL_W'(res.pixel_count);
      end

      if (closes_image) begin
         image_count = '0;
         parse_phase = PH_HEADER;
         pixels_left = '0;
      end else if (in_run || pixels_left == '0) begin
         parse_phase = PH_HEADER;
         pixels_left = '0;
      end else begin
         pixels_left = pixels_left - 8'd1;
      end
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         cfg_bpp = 3'd4;
         cfg_swap = 1'b0;
         cfg_total = 30'd1;
         parse_phase = PH_HEADER;
         in_run = 1'b0;
         pixels_left = '0;
         byte_pos = 2'd0;
         assembly = '0;
         image_count = '0;
         expected_pixels.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BYTES_PER_PIXEL: cfg_bpp = csr_data[2:0];
               CSR_SWAP_RED_BLUE:   cfg_swap = csr_data[0];
               CSR_TOTAL_PIXELS:    cfg_total = csr_data[TOTAL_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            decode_byte(req_tdata);
         // result transaction against the oldest owed result
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected pixel result: tdata %h tlast %b tuser %b",
                      rsp_tdata, rsp_tlast, rsp_tuser);
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               compare_field("first_pixel", want.first_pixel, rsp_tdata[31:0]);
               compare_field("second_pixel", want.second_pixel, rsp_tdata[63:32]);
               compare_field("pixel_count", 32'(want.pixel_count),
                             32'(rsp_tdata[65:64]));
               compare_field("run_end", 32'(want.run_end), 32'(rsp_tlast));
               compare_field("image_end", 32'(want.image_end), 32'(rsp_tuser));
               compare_field("tdata padding", 32'd0, 32'(rsp_tdata[71:66]));
            end
         end
      end
      results_pending <= expected_pixels.size();
      failures <= error_count;
   end

endmodule

// ----- test/tb_tga_rle_pixel_decoder.sv -----
module tb_tga_rle_pixel_decoder;
   import tgarle_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 2_000_000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_BYTES_PER_PIXEL;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [71:0]            rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;

   int results_pending;
   int decode_failures;
   int cycle_count = 0;

   // stall control
   bit   req_steady = 1'b0;
   logic rsp_steady = 1'b0;
   int   stall_left = 0;

   // stream position as the block should see it, used to shape stimulus
   bit          mir_header = 1'b1;
   bit          mir_run = 1'b0;
   logic [6:0]  mir_len = '0;
   int unsigned mir_pos = 0;
   int unsigned mir_bpp = 4;
   int unsigned mir_total = 1;
   int unsigned mir_done = 0;

   tga_rle_pixel_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   tga_rle_decode_check decode_check (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .rsp_tuser       (rsp_tuser),
      .results_pending (results_pending),
      .failures        (decode_failures)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, a few long ones
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 6);
      return $urandom_range(10, 20);
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (!rsp_steady && $urandom_range(0, 4) == 0)
            stall_left = gap_length();
      end
   end

   function automatic int unsigned image_left();
      return (mir_total > mir_done) ? mir_total - mir_done : 1;
   endfunction

   // track packet and image position after each accepted byte
   function automatic void note_byte(input logic [7:0] b);
      int unsigned cnt, left;
      if (mir_header) begin
         mir_run = b[RUN_FLAG_BIT];
         mir_len = b[6:0];
         mir_header = 1'b0;
         mir_pos = 0;
      end else if (mir_pos + 1 < mir_bpp) begin
         mir_pos++;
      end else begin
         mir_pos = 0;
         cnt = mir_run ? mir_len + 1 : 1;
         left = image_left();
         if (cnt >= left) begin
            mir_done = 0;
            mir_header = 1'b1;
         end else begin
            mir_done += cnt;
            if (mir_run || mir_len == '0) mir_header = 1'b1;
            else mir_len = mir_len - 7'd1;
         end
      end
   endfunction

   task automatic push_byte(input logic [7:0] value);
      int gap;
      gap = (!req_steady && $urandom_range(0, 3) == 0) ? gap_length() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      do @(posedge clock); while (!req_tready);
      note_byte(value);
   endtask

   // hold the input until every owed result is out, then let the parser settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_config(input logic [2:0] bpp, input logic swap,
                             input logic [TOTAL_W-1:0] total);
      wait_idle();
      write_csr(CSR_BYTES_PER_PIXEL, CSR_DATA_W'(bpp));
      write_csr(CSR_SWAP_RED_BLUE, CSR_DATA_W'(swap));
      write_csr(CSR_TOTAL_PIXELS, CSR_DATA_W'(total));
      csr_valid <= 1'b0;
      mir_bpp = (bpp == 3'd0) ? 1 : ((bpp > 3'd4) ? 4 : bpp);
      mir_total = (total == '0) ? 1 : total;
   endtask

   // packet header: mostly short packets, some ending exactly at the image
   // end, some long runs, and a share of arbitrary bytes
   function automatic logic [7:0] next_header();
      int unsigned left, cnt;
      logic run;
      if ($urandom_range(0, 9) == 0) return 8'($urandom);
      left = image_left();
      run = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         0, 1: begin
            cnt = (left > 128) ? 128 : left;
            if (!run && cnt > 12) cnt = 12;
         end
         2: cnt = run ? $urandom_range(17, 128) : $urandom_range(5, 12);
         default: cnt = $urandom_range(1, 4);
      endcase
      return {run, 7'(cnt - 1)};
   endfunction

   function automatic logic [7:0] next_pixel_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic swap;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 4-byte pixels, one-pixel image
      push_byte(8'h80);
      push_byte(8'hFF); push_byte(8'h00); push_byte(8'hA5); push_byte(8'h5A);

      // longest run of swapped 3-byte pixels, then a single literal
      set_config(3'd3, 1'b1, 30'd1000);
      push_byte(8'hFF);
      push_byte(8'h11); push_byte(8'h22); push_byte(8'h33);
      push_byte(8'h00);
      push_byte(8'hFF); push_byte(8'h00); push_byte(8'hAB);

      // longest literal cut by the image end; the next byte parses as a header
      set_config(3'd1, 1'b1, 30'd3);
      push_byte(8'h7F);
      push_byte(8'h01); push_byte(8'h80); push_byte(8'hFE);
      push_byte(8'h81); push_byte(8'h7E);

      // total lowered to the pixels already done: next pixel closes the image
      set_config(3'd2, 1'b0, 30'd2);
      push_byte(8'h83); push_byte(8'hC3); push_byte(8'h3C);

      // pixel size shrunk in the middle of a pixel
      set_config(3'd4, 1'b0, 30'd2);
      push_byte(8'h00); push_byte(8'h12); push_byte(8'h34);
      set_config(3'd2, 1'b0, 30'd2);
      push_byte(8'h56);

      // random streams over a range of settings
      for (int ph = 0; ph < 8; ph++) begin
         swap = 1'($urandom_range(0, 1));
         case (ph)
            0: set_config(3'd1, swap, 30'd1);
            1: set_config(3'd2, swap, 30'd2);
            2: set_config(3'd3, swap, 30'd9);
            3: set_config(3'd4, swap, 30'd60);
            4: set_config(3'd0, swap, 30'd0);
            5: set_config(3'd5, swap, 30'h3FFF_FFFF);
            6: set_config(3'd7, swap, 30'd1073676289);
            default: set_config(3'd6, swap, 30'd5);
         endcase
         req_steady = ($urandom_range(0, 2) == 0);
         rsp_steady <= ($urandom_range(0, 2) == 0);
         for (int i = 0; i < 29; i++) begin
            if (mir_header) push_byte(next_header());
            else push_byte(next_pixel_byte());
            if ($urandom_range(0, 49) == 0) wait_idle();
            if ($urandom_range(0, 19) == 0) req_steady = !req_steady;
            if ($urandom_range(0, 19) == 0) rsp_steady <= !rsp_steady;
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (decode_failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- tga_rle_pixel_decoder.f -----
hdl/tgarle_pkg.sv
hdl/tgarle_fifo.sv
hdl/tgarle_front.sv
hdl/tgarle_back.sv
hdl/tga_rle_pixel_decoder.sv
test/tga_rle_decode_check.sv
test/tb_tga_rle_pixel_decoder.sv
